>>> src/sogi_quadrature_generator_unit_macros.svh
// Assertion helpers shared by the SOGI quadrature generator RTL.
`ifndef SOGI_QUADRATURE_GENERATOR_UNIT_MACROS_SVH
`define SOGI_QUADRATURE_GENERATOR_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define SOGI_QG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SOGI_QG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/sogi_qg_pkg.sv
package sogi_qg_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int COEF_BITS      = 32;
	localparam int COEF_FRAC_BITS = 30;
	localparam int HIST_BITS      = 32;
	// history carries 4 guard bits above sample full scale
	localparam int HIST_EXTRA     = HIST_BITS - 4 - SAMPLE_BITS;
	localparam int CFG_IDX_BITS   = 2;

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [COEF_BITS-1:0]   coef_t;
	typedef logic signed [HIST_BITS-1:0]   hist_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_ALPHA_GAIN   = 2'd0,
		REG_BETA_GAIN    = 2'd1,
		REG_FEEDBACK_ONE = 2'd2,
		REG_FEEDBACK_TWO = 2'd3
	} cfg_reg_t;

	localparam coef_t ALPHA_GAIN_RST   = 32'sd11792778;
	localparam coef_t BETA_GAIN_RST    = 32'sd92622;
	localparam coef_t FEEDBACK_ONE_RST = 32'sd2123631548;
	localparam coef_t FEEDBACK_TWO_RST = -32'sd1050152573;

endpackage

>>> src/sogi_qg_sample_if.sv
interface sogi_qg_sample_if;
	logic                 valid;
	logic                 ready;
	sogi_qg_pkg::sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

>>> src/sogi_qg_result_if.sv
interface sogi_qg_result_if;
	logic                 valid;
	logic                 ready;
	sogi_qg_pkg::sample_t alpha_out;
	sogi_qg_pkg::sample_t beta_out;

	modport source (output valid, output alpha_out, output beta_out, input ready);
	modport sink (input valid, input alpha_out, input beta_out, output ready);
endinterface

>>> src/sogi_qg_cfg_if.sv
interface sogi_qg_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [sogi_qg_pkg::CFG_IDX_BITS-1:0] index;
	sogi_qg_pkg::coef_t                   data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

>>> src/sogi_quadrature_generator_unit.sv
// SOGI quadrature generator: second-order generalized integrator, Tustin form.
// smp (sink): one signed sample per transfer. res (source): one alpha/beta
// pair per sample, in order, both rounded and saturated to the sample range.
// cfg (sink): register writes, index 0 alpha_gain, 1 beta_gain, 2 feedback_one,
// 3 feedback_two, signed Q2.30; always ready, write only while idle.
// Registers: input sample_s1, then alpha_out_q/beta_out_q driving res.
// Throughput: one sample per cycle while res takes each result. The limit
// is the per-sample feedback loop: coefficient times last history, three-term
// sum and 32-bit saturation are one combinational path, as the next sample
// needs the result. A stalled res keeps its result; one more sample can
// wait in the input register, then smp.ready drops until res is taken.
// Reset: coefficients return to their defaults, sample and filter histories
// clear to zero, both pipeline registers empty.
`include "sogi_quadrature_generator_unit_macros.svh"

module sogi_quadrature_generator_unit (
	input  logic             clk,
	input  logic             arst_n,
	sogi_qg_sample_if.sink   smp,
	sogi_qg_result_if.source res,
	sogi_qg_cfg_if.sink      cfg
);

	localparam int PROD_BITS = sogi_qg_pkg::COEF_BITS + sogi_qg_pkg::HIST_BITS;
	localparam int TERM_BITS = PROD_BITS - sogi_qg_pkg::COEF_FRAC_BITS;
	localparam int SUM_BITS  = TERM_BITS + 2;
	localparam int HB        = sogi_qg_pkg::HIST_BITS;
	localparam int HE        = sogi_qg_pkg::HIST_EXTRA;
	localparam int SB        = sogi_qg_pkg::SAMPLE_BITS;
	localparam logic signed [HB:0] ROUND_HALF = (HB+1)'(1) << (HE - 1);

	// floor(coef * operand / 2^frac)
	function automatic logic signed [TERM_BITS-1:0] scaled_product(
		input sogi_qg_pkg::coef_t c,
		input sogi_qg_pkg::hist_t op
	);
		logic signed [PROD_BITS-1:0] p;
		p = PROD_BITS'(c) * PROD_BITS'(op);
		return TERM_BITS'(p >>> sogi_qg_pkg::COEF_FRAC_BITS);
	endfunction

	function automatic sogi_qg_pkg::hist_t sat_hist(input logic signed [SUM_BITS-1:0] s);
		logic [SUM_BITS-HB:0] top;
		top = s[SUM_BITS-1:HB-1];
		if ((&top) || !(|top)) begin
			return s[HB-1:0];
		end
		return s[SUM_BITS-1] ? {1'b1, {(HB-1){1'b0}}} : {1'b0, {(HB-1){1'b1}}};
	endfunction

	// round half up to sample scale, then saturate
	function automatic sogi_qg_pkg::sample_t to_output(input sogi_qg_pkg::hist_t h);
		logic signed [HB:0]   r;
		logic [HB-HE:0]       q;
		logic [HB-HE-SB+1:0]  top;
		r   = (HB+1)'(h) + ROUND_HALF;
		q   = r[HB:HE];
		top = q[HB-HE:SB-1];
		if ((&top) || !(|top)) begin
			return q[SB-1:0];
		end
		return q[HB-HE] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
	endfunction

	sogi_qg_pkg::coef_t   alpha_gain_q, beta_gain_q, feedback_one_q, feedback_two_q;
	sogi_qg_pkg::sample_t smp_hist_q [2];
	sogi_qg_pkg::hist_t   alpha_hist_q [2];
	sogi_qg_pkg::hist_t   beta_hist_q [2];

	logic                 valid_s1;
	sogi_qg_pkg::sample_t sample_s1;
	logic                 res_valid_q;
	sogi_qg_pkg::sample_t alpha_out_q, beta_out_q;

	logic                 advance;
	logic signed [SB:0]   diff;
	logic signed [SB+2:0] wsum;
	sogi_qg_pkg::hist_t   alpha_opd, beta_opd;
	logic signed [SUM_BITS-1:0] alpha_sum, beta_sum;
	sogi_qg_pkg::hist_t   alpha_new, beta_new;

	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign smp.ready = !valid_s1 || advance;
	assign cfg.ready = 1'b1;

	assign res.valid     = res_valid_q;
	assign res.alpha_out = alpha_out_q;
	assign res.beta_out  = beta_out_q;

	// feedforward operands in history scale
	assign diff      = (SB+1)'(sample_s1) - (SB+1)'(smp_hist_q[1]);
	assign wsum      = (SB+3)'(sample_s1) + ((SB+3)'(smp_hist_q[0]) <<< 1)
		+ (SB+3)'(smp_hist_q[1]);
	assign alpha_opd = HB'(diff) <<< HE;
	assign beta_opd  = HB'(wsum) <<< HE;

	assign alpha_sum = SUM_BITS'(scaled_product(alpha_gain_q, alpha_opd))
		+ SUM_BITS'(scaled_product(feedback_one_q, alpha_hist_q[0]))
		+ SUM_BITS'(scaled_product(feedback_two_q, alpha_hist_q[1]));
	assign beta_sum  = SUM_BITS'(scaled_product(beta_gain_q, beta_opd))
		+ SUM_BITS'(scaled_product(feedback_one_q, beta_hist_q[0]))
		+ SUM_BITS'(scaled_product(feedback_two_q, beta_hist_q[1]));

	assign alpha_new = sat_hist(alpha_sum);
	assign beta_new  = sat_hist(beta_sum);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_gain_q   <= sogi_qg_pkg::ALPHA_GAIN_RST;
			beta_gain_q    <= sogi_qg_pkg::BETA_GAIN_RST;
			feedback_one_q <= sogi_qg_pkg::FEEDBACK_ONE_RST;
			feedback_two_q <= sogi_qg_pkg::FEEDBACK_TWO_RST;
		end else if (cfg.valid) begin
			unique case (sogi_qg_pkg::cfg_reg_t'(cfg.index))
				sogi_qg_pkg::REG_ALPHA_GAIN:   alpha_gain_q   <= cfg.data;
				sogi_qg_pkg::REG_BETA_GAIN:    beta_gain_q    <= cfg.data;
				sogi_qg_pkg::REG_FEEDBACK_ONE: feedback_one_q <= cfg.data;
				sogi_qg_pkg::REG_FEEDBACK_TWO: feedback_two_q <= cfg.data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (smp.ready) begin
				valid_s1 <= smp.valid;
			end
			if (advance) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// filter state moves only when a sample leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_hist_q[0]   <= '0;
			smp_hist_q[1]   <= '0;
			alpha_hist_q[0] <= '0;
			alpha_hist_q[1] <= '0;
			beta_hist_q[0]  <= '0;
			beta_hist_q[1]  <= '0;
		end else if (advance) begin
			smp_hist_q[0]   <= sample_s1;
			smp_hist_q[1]   <= smp_hist_q[0];
			alpha_hist_q[0] <= alpha_new;
			alpha_hist_q[1] <= alpha_hist_q[0];
			beta_hist_q[0]  <= beta_new;
			beta_hist_q[1]  <= beta_hist_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (smp.valid && smp.ready) begin
			sample_s1 <= smp.sample;
		end
		if (advance) begin
			alpha_out_q <= to_output(alpha_new);
			beta_out_q  <= to_output(beta_new);
		end
	end

	`SOGI_QG_ASSERT_NEXT(a_adv_fills_res, clk, arst_n, advance, res_valid_q, "result lost after advance")
	`SOGI_QG_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1 && !advance, valid_s1 && $stable(sample_s1), "input register dropped a waiting sample")
	`SOGI_QG_ASSERT_NEXT(a_smp_shift, clk, arst_n, advance, smp_hist_q[0] == $past(sample_s1) && smp_hist_q[1] == $past(smp_hist_q[0]), "sample history shift wrong")
	`SOGI_QG_ASSERT_NEXT(a_hist_hold, clk, arst_n, !advance, $stable(alpha_hist_q[0]) && $stable(beta_hist_q[0]), "filter history moved without a sample")
	`SOGI_QG_ASSERT_SAME(a_stall_blocks, clk, arst_n, res_valid_q && !res.ready, !advance, "advance while result stalled")

endmodule

>>> bench/tb_top.sv
module tb_top;
	import sogi_qg_pkg::*;

	localparam int CYCLE_LIMIT  = 250000;
	localparam int RANDOM_ITEMS = 1650;

	typedef struct packed {
		sample_t alpha;
		sample_t beta;
	} quad_pair_t;

	typedef enum int {
		WAVE_FULL,
		WAVE_SMALL,
		WAVE_RAILS,
		WAVE_TRIANGLE
	} wave_mode_t;

	logic clk;
	logic arst_n;

	sogi_qg_sample_if smp_if();
	sogi_qg_result_if res_if();
	sogi_qg_cfg_if    cfg_if();

	sogi_quadrature_generator_unit u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.smp   (smp_if),
		.res   (res_if),
		.cfg   (cfg_if)
	);

	// predictor copy of coefficients and filter history
	coef_t   gain_alpha;
	coef_t   gain_beta;
	coef_t   fb_one;
	coef_t   fb_two;
	sample_t x_prev1;
	sample_t x_prev2;
	hist_t   alpha_h1;
	hist_t   alpha_h2;
	hist_t   beta_h1;
	hist_t   beta_h2;

	quad_pair_t  expected_pairs[$];
	int unsigned mismatches  = 0;
	int unsigned cycle_count = 0;
	bit          no_idle     = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void clear_filter_state();
		gain_alpha = ALPHA_GAIN_RST;
		gain_beta  = BETA_GAIN_RST;
		fb_one     = FEEDBACK_ONE_RST;
		fb_two     = FEEDBACK_TWO_RST;
		x_prev1    = '0;
		x_prev2    = '0;
		alpha_h1   = '0;
		alpha_h2   = '0;
		beta_h1    = '0;
		beta_h2    = '0;
	endfunction

	// exact product, then floor shift out the coefficient fraction
	function automatic longint coef_mul(coef_t c, longint op);
		longint p;
		p = longint'(c) * op;
		return p >>> COEF_FRAC_BITS;
	endfunction

	function automatic hist_t clamp_hist(longint v);
		if (v > 64'sd2147483647)
			return 32'sh7fffffff;
		if (v < -64'sd2147483648)
			return 32'sh80000000;
		return hist_t'(v);
	endfunction

	// round half up, drop guard scaling, clamp to sample range
	function automatic sample_t hist_to_sample(hist_t h);
		longint r;
		longint lim;
		lim = longint'(1) << (SAMPLE_BITS - 1);
		r = (longint'(h) + (longint'(1) << (HIST_EXTRA - 1))) >>> HIST_EXTRA;
		if (r > lim - 1)
			r = lim - 1;
		else if (r < -lim)
			r = -lim;
		return sample_t'(r);
	endfunction

	function automatic quad_pair_t sogi_step(sample_t x0);
		longint     up;
		longint     acc_a;
		longint     acc_b;
		hist_t      na;
		hist_t      nb;
		quad_pair_t r;
		up = longint'(1) << HIST_EXTRA;
		acc_a = coef_mul(gain_alpha, (longint'(x0) - longint'(x_prev2)) * up)
			+ coef_mul(fb_one, longint'(alpha_h1))
			+ coef_mul(fb_two, longint'(alpha_h2));
		acc_b = coef_mul(gain_beta,
			(longint'(x0) + 2 * longint'(x_prev1) + longint'(x_prev2)) * up)
			+ coef_mul(fb_one, longint'(beta_h1))
			+ coef_mul(fb_two, longint'(beta_h2));
		na = clamp_hist(acc_a);
		nb = clamp_hist(acc_b);
		x_prev2  = x_prev1;
		x_prev1  = x0;
		alpha_h2 = alpha_h1;
		alpha_h1 = na;
		beta_h2  = beta_h1;
		beta_h1  = nb;
		r.alpha = hist_to_sample(na);
		r.beta  = hist_to_sample(nb);
		return r;
	endfunction

	function automatic void log_error(string what);
		mismatches++;
		if (mismatches <= 10)
			$display("ERROR: %s", what);
	endfunction

	// result check first: a sample taken at this edge cannot have its result here yet
	always @(posedge clk) begin : monitor
		quad_pair_t want;
		if (arst_n) begin
			if (res_if.valid && res_if.ready) begin
				if (expected_pairs.size() == 0) begin
					log_error($sformatf("unexpected result alpha %0d beta %0d",
						res_if.alpha_out, res_if.beta_out));
				end else begin
					want = expected_pairs.pop_front();
					if (res_if.alpha_out !== want.alpha || res_if.beta_out !== want.beta)
						log_error($sformatf(
							"alpha exp %0d got %0d, beta exp %0d got %0d",
							want.alpha, res_if.alpha_out, want.beta, res_if.beta_out));
				end
			end
			if (cfg_if.valid && cfg_if.ready) begin
				case (cfg_reg_t'(cfg_if.index))
					REG_ALPHA_GAIN:   gain_alpha = cfg_if.data;
					REG_BETA_GAIN:    gain_beta  = cfg_if.data;
					REG_FEEDBACK_ONE: fb_one     = cfg_if.data;
					REG_FEEDBACK_TWO: fb_two     = cfg_if.data;
				endcase
			end
			if (smp_if.valid && smp_if.ready)
				expected_pairs.push_back(sogi_step(smp_if.sample));
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL sogi_quadrature_generator_unit");
			$finish;
		end
	end

	initial begin : result_sink
		int stall;
		res_if.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				res_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_if.ready <= 1'b1;
			do @(posedge clk); while (!res_if.valid);
		end
	end

	// valid stays high into the next transfer when the next gap is zero
	task automatic send_sample(sample_t s);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			smp_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp_if.valid  <= 1'b1;
		smp_if.sample <= s;
		do @(posedge clk); while (!smp_if.ready);
	endtask

	task automatic settle();
		smp_if.valid <= 1'b0;
		@(posedge clk);
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_coefs(coef_t g, coef_t h, coef_t f1, coef_t f2);
		coef_t    vals[4];
		cfg_reg_t regs[4];
		vals = '{g, h, f1, f2};
		regs = '{REG_ALPHA_GAIN, REG_BETA_GAIN, REG_FEEDBACK_ONE, REG_FEEDBACK_TWO};
		cfg_if.valid <= 1'b1;
		for (int i = 0; i < 4; i++) begin
			cfg_if.index <= regs[i];
			cfg_if.data  <= vals[i];
			do @(posedge clk); while (!cfg_if.ready);
		end
		cfg_if.valid <= 1'b0;
	endtask

	function automatic coef_t corner_coef();
		case ($urandom_range(0, 4))
			0:       return 32'sh7fffffff;
			1:       return 32'sh80000000;
			2:       return '0;
			3:       return 32'sd1;
			default: return -32'sd1;
		endcase
	endfunction

	// impulses through the reset coefficients
	task automatic test_default_response();
		send_sample(16'sh7fff);
		send_sample('0);
		send_sample('0);
		send_sample('0);
		send_sample(16'sh8000);
		send_sample('0);
		send_sample('0);
		send_sample(-16'sd1);
		send_sample(16'sd1);
	endtask

	// full-scale gain on a rail-to-rail step drives both outputs past the sample range
	task automatic test_output_saturation();
		settle();
		set_coefs(32'sh7fffffff, 32'sh7fffffff, '0, '0);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
	endtask

	// feedback at both extremes makes the history run into its 32-bit rails
	task automatic test_history_saturation();
		settle();
		set_coefs(32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		send_sample(16'sh8000);
		send_sample(16'sh7fff);
		settle();
		set_coefs(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		repeat (4) send_sample(16'sh7fff);
	endtask

	task automatic test_random_stream();
		int         sent;
		int         span;
		int         level;
		int         dir;
		int         step;
		wave_mode_t wave;
		sample_t    s;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			settle();
			case ($urandom_range(0, 3))
				0: set_coefs(ALPHA_GAIN_RST, BETA_GAIN_RST, FEEDBACK_ONE_RST, FEEDBACK_TWO_RST);
				1: set_coefs(coef_t'($urandom()), coef_t'($urandom()),
					coef_t'($urandom()), coef_t'($urandom()));
				2: set_coefs(corner_coef(), corner_coef(), corner_coef(), corner_coef());
				default: set_coefs(ALPHA_GAIN_RST + coef_t'($urandom_range(0, 1 << 24)),
					BETA_GAIN_RST + coef_t'($urandom_range(0, 1 << 20)),
					FEEDBACK_ONE_RST - coef_t'($urandom_range(0, 1 << 22)),
					FEEDBACK_TWO_RST + coef_t'($urandom_range(0, 1 << 22)));
			endcase
			wave    = wave_mode_t'($urandom_range(0, 3));
			no_idle = ($urandom_range(0, 3) == 0);
			span    = $urandom_range(40, 150);
			level   = $urandom_range(0, 20000) - 10000;
			dir     = 1;
			step    = $urandom_range(50, 4000);
			repeat (span) begin
				case (wave)
					WAVE_FULL:  s = sample_t'($urandom());
					WAVE_SMALL: s = sample_t'($urandom_range(0, 511) - 256);
					WAVE_RAILS: begin
						case ($urandom_range(0, 2))
							0:       s = 16'sh7fff;
							1:       s = 16'sh8000;
							default: s = '0;
						endcase
					end
					default: begin
						level += dir * step;
						if (level > 32000) begin
							level = 32000;
							dir   = -1;
						end else if (level < -32000) begin
							level = -32000;
							dir   = 1;
						end
						// occasional glitch on the otherwise smooth wave
						if ($urandom_range(0, 15) == 0)
							s = sample_t'($urandom());
						else
							s = sample_t'(level);
					end
				endcase
				send_sample(s);
				sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		smp_if.valid  <= 1'b0;
		smp_if.sample <= '0;
		cfg_if.valid  <= 1'b0;
		cfg_if.index  <= REG_ALPHA_GAIN;
		cfg_if.data   <= '0;
		arst_n = 1'b0;
		clear_filter_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_response();
		test_output_saturation();
		test_history_saturation();
		test_random_stream();
		settle();
		if (mismatches == 0)
			$display("PASS sogi_quadrature_generator_unit");
		else
			$display("FAIL sogi_quadrature_generator_unit");
		$finish;
	end

endmodule
